FILE: rtl/sasf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-and stream filter package
// Widths, item kinds, register indexes and the control/status structs shared
// by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package sasf_pkg;

   // Field widths.
   localparam int CHAR_W      = 8;
   localparam int PAT_W       = 16;
   localparam int POS_W       = 4;
   localparam int NL_W        = 2;
   localparam int KIND_W      = 2;
   localparam int LEN_W       = 5;
   localparam int TABLE_DEPTH = 256;
   localparam int WIN_DEPTH   = 16;
   localparam int REQ_DATA_W  = 32;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 8;
   localparam int RSP_USER_W  = 2;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 16;

   // Item kinds carried in req_tuser.
   localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_MASK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOAD_NL = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd3;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_LENGTH = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEEP_MASK      = 1'b1;

   // Character codes.
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

   // Commands from the controller to the datapath. The walk position and
   // newline count travel on their own ports so that the status never
   // depends on this struct.
   typedef struct packed {
      logic             load_mask;
      logic             load_nl;
      logic             restart;
      logic             start_text;
      logic             update;
      logic             walk_push;
      logic             walk_nl;
      logic             single;
      logic             flush;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic match_now;
      logic out_free;
      logic pend_valid;
      logic nl_more;
      logic keep_bit;
      logic at_end;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: rtl/sasf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-and stream filter controller
// Sequences item intake, the match vector update, the match emission walk
// over pattern positions and the final beat of every text character.
// ----------------------------------------------------------------------------
module sasf_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [sasf_pkg::KIND_W-1:0] req_kind,
   input  sasf_pkg::dp_status_type     st,
   output sasf_pkg::ctl_cmd_type       cmd,
   output logic [sasf_pkg::POS_W-1:0]  walk_pos,
   output logic [sasf_pkg::NL_W-1:0]   walk_cnt
);
   import sasf_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_SINGLE = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_FLUSH  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [NL_W-1:0]  cnt_ff, cnt_in;
   logic             accept;
   logic             emit_now;
   logic             stall;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Walk position and newline count straight from the counters.
   assign walk_pos = pos_ff;
   assign walk_cnt = cnt_ff;

   // A walk step that emits must first pass the pending beat to the output.
   assign emit_now = st.nl_more || st.keep_bit;
   assign stall    = emit_now && st.pend_valid && !st.out_free;

   // Command decode.
   always_comb begin
      cmd            = '0;
      cmd.walk_nl    = st.nl_more;
      cmd.load_mask  = accept && (req_kind == KIND_LOAD_MASK);
      cmd.load_nl    = accept && (req_kind == KIND_LOAD_NL);
      cmd.restart    = accept && (req_kind == KIND_RESTART);
      cmd.start_text = accept && (req_kind == KIND_TEXT);
      cmd.update     = (state_ff == ST_UPDATE);
      cmd.walk_push  = (state_ff == ST_WALK) && emit_now && !stall;
      cmd.single     = (state_ff == ST_SINGLE) && st.out_free;
      cmd.flush      = (state_ff == ST_FLUSH) && st.out_free;
   end

   // Next state and walk counters.
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start_text) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            pos_in = '0;
            cnt_in = '0;
            if (st.match_now) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_SINGLE;
            end
         end
         ST_SINGLE: begin
            if (st.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (!stall) begin
               if (st.nl_more) begin
                  cnt_in = cnt_ff + NL_W'(1);
               end else begin
                  cnt_in = '0;
                  if (st.at_end) begin
                     state_in = ST_FLUSH;
                  end else begin
                     pos_in = pos_ff + POS_W'(1);
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (st.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sasf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-and stream filter datapath
// Holds the registers, the character mask memory, the newline table, the
// window ring, the match vector, a pending beat and the output register.
// ----------------------------------------------------------------------------
module sasf_dp (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_we,
   input  wire  [sasf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire  [sasf_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire  [sasf_pkg::CHAR_W-1:0]     req_char_code,
   input  wire  [sasf_pkg::PAT_W-1:0]      req_mask_word,
   input  wire  [sasf_pkg::POS_W-1:0]      req_position,
   input  wire  [sasf_pkg::NL_W-1:0]       req_newline_count,
   input  sasf_pkg::ctl_cmd_type           cmd,
   input  wire  [sasf_pkg::POS_W-1:0]      walk_pos,
   input  wire  [sasf_pkg::NL_W-1:0]       walk_cnt,
   output sasf_pkg::dp_status_type         st,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [sasf_pkg::CHAR_W-1:0]     rsp_char,
   output logic                            rsp_char_valid,
   output logic                            rsp_matched,
   output logic                            rsp_last
);
   import sasf_pkg::*;

   // Registers and state.
   logic [LEN_W-1:0]  plen_ff;
   logic [PAT_W-1:0]  keep_ff;
   logic [PAT_W-1:0]  mv_ff, mv_in;
   logic [POS_W-1:0]  wp_ff, wp_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic              full_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [PAT_W-1:0]  mask_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] mask_vld_ff;
   logic [PAT_W-1:0]  mask_rd_ff;
   logic              mask_rd_vld_ff;
   logic [NL_W-1:0]   nl_tab_ff [WIN_DEPTH];
   logic [CHAR_W-1:0] ring_ff [WIN_DEPTH];
   logic              pend_valid_ff;
   logic [CHAR_W-1:0] pend_char_ff;
   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff;
   logic              out_cvalid_ff;
   logic              out_matched_ff;
   logic              out_last_ff;

   // Combinational terms.
   logic [LEN_W-1:0]  len_eff;
   logic [LEN_W-1:0]  len_m1_w;
   logic [POS_W-1:0]  len_m1;
   logic [PAT_W-1:0]  mask_eff;
   logic [POS_W-1:0]  wp_eff;
   logic [LEN_W-1:0]  wp_inc;
   logic [LEN_W-1:0]  fill_inc;
   logic [LEN_W-1:0]  walk_sum;
   logic [LEN_W-1:0]  walk_idx_w;
   logic [POS_W-1:0]  rd_idx;
   logic [CHAR_W-1:0] ring_rd;
   logic [CHAR_W-1:0] old_char;
   logic              out_free;
   logic              out_load;

   // Effective pattern length: zero counts as one, the top is clamped.
   always_comb begin
      if (plen_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (plen_ff > LEN_W'(PAT_W)) begin
         len_eff = LEN_W'(PAT_W);
      end else begin
         len_eff = plen_ff;
      end
   end
   assign len_m1_w = len_eff - LEN_W'(1);
   assign len_m1   = len_m1_w[POS_W-1:0];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= LEN_W'(1);
         keep_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PATTERN_LENGTH: plen_ff <= csr_wdata[LEN_W-1:0];
            CSR_KEEP_MASK:      keep_ff <= csr_wdata[PAT_W-1:0];
            default:            ;
         endcase
      end
   end

   // Character mask memory with a registered read.
   always_ff @(posedge clock) begin
      if (cmd.load_mask) begin
         mask_mem[req_char_code] <= req_mask_word;
      end
      if (cmd.start_text) begin
         mask_rd_ff <= mask_mem[req_char_code];
      end
   end

   // Entry valid bits stand in for the all-zero reset of the mask memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_vld_ff    <= '0;
         mask_rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.load_mask) begin
            mask_vld_ff[req_char_code] <= 1'b1;
         end
         if (cmd.start_text) begin
            mask_rd_vld_ff <= mask_vld_ff[req_char_code];
         end
      end
   end

   // Newline count table.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WIN_DEPTH; k++) begin
            nl_tab_ff[k] <= '0;
         end
      end else if (cmd.load_nl) begin
         nl_tab_ff[req_position] <= req_newline_count;
      end
   end

   // Text character capture.
   always_ff @(posedge clock) begin
      if (cmd.start_text) begin
         char_ff <= req_char_code;
      end
   end

   // Match vector, write pointer and fill count update.
   assign mask_eff = mask_rd_vld_ff ? mask_rd_ff : '0;
   assign mv_in    = ({mv_ff[PAT_W-2:0], 1'b0} | PAT_W'(1)) & mask_eff;
   assign wp_eff   = ({1'b0, wp_ff} >= len_eff) ? '0 : wp_ff;
   assign wp_inc   = {1'b0, wp_eff} + LEN_W'(1);
   assign wp_in    = (wp_inc == len_eff) ? '0 : wp_inc[POS_W-1:0];
   assign fill_inc = (fill_ff < len_eff) ? (fill_ff + LEN_W'(1)) : len_eff;
   assign fill_in  = mv_in[len_m1] ? '0 : fill_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff   <= '0;
         wp_ff   <= '0;
         fill_ff <= '0;
         full_ff <= 1'b0;
      end else if (cmd.restart) begin
         mv_ff   <= '0;
         fill_ff <= '0;
      end else if (cmd.update) begin
         mv_ff   <= mv_in;
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         full_ff <= (fill_inc == len_eff);
      end
   end

   // Window ring write.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_ff[wp_eff] <= char_ff;
      end
   end

   // Window ring read: the oldest character, or the walked position.
   assign walk_sum   = {1'b0, wp_ff} + {1'b0, walk_pos};
   assign walk_idx_w = (walk_sum >= len_eff) ? (walk_sum - len_eff) : walk_sum;
   assign rd_idx     = cmd.single ? wp_ff : walk_idx_w[POS_W-1:0];
   assign ring_rd    = ring_ff[rd_idx];
   assign old_char   = (ring_rd == NEWLINE_CODE) ? SPACE_CODE : ring_rd;

   // Pending beat: held back until it is known whether it is the last one.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.walk_push) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_push) begin
         pend_char_ff <= cmd.walk_nl ? NEWLINE_CODE : ring_rd;
      end
   end

   // Output register.
   assign out_free     = !out_valid_ff || rsp_tready;
   assign out_load     = (cmd.walk_push && pend_valid_ff) || cmd.flush || cmd.single;
   assign out_valid_in = out_load ? 1'b1 : (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.single) begin
         out_char_ff    <= full_ff ? old_char : '0;
         out_cvalid_ff  <= full_ff;
         out_matched_ff <= 1'b0;
         out_last_ff    <= 1'b1;
      end else if (cmd.flush) begin
         out_char_ff    <= pend_valid_ff ? pend_char_ff : '0;
         out_cvalid_ff  <= pend_valid_ff;
         out_matched_ff <= 1'b1;
         out_last_ff    <= 1'b1;
      end else if (cmd.walk_push && pend_valid_ff) begin
         out_char_ff    <= pend_char_ff;
         out_cvalid_ff  <= 1'b1;
         out_matched_ff <= 1'b1;
         out_last_ff    <= 1'b0;
      end
   end

   assign rsp_tvalid     = out_valid_ff;
   assign rsp_char       = out_char_ff;
   assign rsp_char_valid = out_cvalid_ff;
   assign rsp_matched    = out_matched_ff;
   assign rsp_last       = out_last_ff;

   // Status to the controller.
   assign st.match_now  = mv_in[len_m1];
   assign st.out_free   = out_free;
   assign st.pend_valid = pend_valid_ff;
   assign st.nl_more    = (walk_cnt < nl_tab_ff[walk_pos]);
   assign st.keep_bit   = keep_ff[walk_pos];
   assign st.at_end     = (walk_pos == len_m1);

endmodule
`default_nettype wire

FILE: rtl/shift_and_stream_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-and stream filter
// Streaming shift-and matcher that rewrites a character stream on a match.
//
// Channel   Direction  Beat contents
// req_*     in         tuser: kind; tdata: char_code, mask_word, position,
//                      newline_count
// rsp_*     out        tuser: char_valid, matched; tdata: out_char;
//                      tlast: last
// csr_*     in         write of pattern_length (0) or keep_mask (1)
//
// Load and restart beats complete on intake. A text character passes through
// intake with the mask memory read, the vector update, then the result beat;
// no new request is taken until it is done. On a match a walk over the pattern
// positions emits each position's newlines and, where kept, its character,
// and its final beat takes the place of the result beat. Reset is synchronous;
// there is no clearing pass. A stalled result channel holds the walk only when
// the output register and the pending beat are both full.
// ----------------------------------------------------------------------------
module shift_and_stream_filter (
   input  wire                             clock,
   input  wire                             reset,
   // Configuration write port.
   input  wire                             csr_we,
   input  wire  [sasf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire  [sasf_pkg::CSR_DATA_W-1:0] csr_wdata,
   // Input stream.
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // tdata: char_code[7:0], mask_word[23:8], position[27:24],
   //        newline_count[29:28], zero fill[31:30]
   input  wire  [sasf_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: kind[1:0]
   input  wire  [sasf_pkg::REQ_USER_W-1:0] req_tuser,
   // Result stream.
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // tdata: out_char[7:0]
   output logic [sasf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: char_valid[0], matched[1]
   output logic [sasf_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import sasf_pkg::*;

   localparam int MASK_LSB = CHAR_W;
   localparam int POS_LSB  = MASK_LSB + PAT_W;
   localparam int NL_LSB   = POS_LSB + POS_W;

   ctl_cmd_type       cmd;
   dp_status_type     st;
   logic [POS_W-1:0]  walk_pos;
   logic [NL_W-1:0]   walk_cnt;
   logic [CHAR_W-1:0] req_char_code;
   logic [PAT_W-1:0]  req_mask_word;
   logic [POS_W-1:0]  req_position;
   logic [NL_W-1:0]   req_newline_count;
   logic [CHAR_W-1:0] rsp_char;
   logic              rsp_char_valid;
   logic              rsp_matched;

   // Input beat unpacking.
   assign req_char_code     = req_tdata[CHAR_W-1:0];
   assign req_mask_word     = req_tdata[POS_LSB-1:MASK_LSB];
   assign req_position      = req_tdata[NL_LSB-1:POS_LSB];
   assign req_newline_count = req_tdata[NL_LSB+NL_W-1:NL_LSB];

   sasf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser[KIND_W-1:0]),
      .st         (st),
      .cmd        (cmd),
      .walk_pos   (walk_pos),
      .walk_cnt   (walk_cnt)
   );

   sasf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_char_code     (req_char_code),
      .req_mask_word     (req_mask_word),
      .req_position      (req_position),
      .req_newline_count (req_newline_count),
      .cmd               (cmd),
      .walk_pos          (walk_pos),
      .walk_cnt          (walk_cnt),
      .st                (st),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_char          (rsp_char),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_matched       (rsp_matched),
      .rsp_last          (rsp_tlast)
   );

   // Result beat packing.
   assign rsp_tdata = rsp_char;
   assign rsp_tuser = {rsp_matched, rsp_char_valid};

endmodule
`default_nettype wire

FILE: tb/shift_and_stream_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shift-and stream filter testbench
// A clocked driver feeds request beats from a backlog queue that the stimulus
// process fills. A clocked monitor checks every response beat against the
// beats that an in-bench matcher model predicts for each accepted request.
// The run covers several register settings and idle and stall patterns.
// ----------------------------------------------------------------------------
module shift_and_stream_filter_tb;
   import sasf_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] char_code;
      logic [PAT_W-1:0]  mask_word;
      logic [POS_W-1:0]  position;
      logic [NL_W-1:0]   nl_count;
   } req_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              char_valid;
      logic              matched;
      logic              last;
   } rsp_beat_type;

   // Clock, reset and block inputs, all known from time zero.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   // Stimulus and checking bookkeeping.
   req_item_type req_backlog[$];
   rsp_beat_type owed_beats[$];
   req_item_type cur_item;
   int        sender_idle_pct = 0;
   int        recv_stall_pct  = 0;
   int        error_count     = 0;
   int        req_beats       = 0;
   int        text_beats      = 0;
   int        rsp_beats       = 0;
   int        match_beats     = 0;
   int        cycle_count     = 0;

   // Matcher model state and its copy of the registers.
   logic [LEN_W-1:0]  cfg_len;
   logic [PAT_W-1:0]  cfg_keep;
   logic [PAT_W-1:0]  match_vec;
   logic [CHAR_W-1:0] ring [WIN_DEPTH];
   int                wr_ptr;
   int                fill;
   logic [PAT_W-1:0]  mask_tab [TABLE_DEPTH];
   logic [NL_W-1:0]   nl_tab [WIN_DEPTH];

   shift_and_stream_filter dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int window_span(input logic [LEN_W-1:0] len);
      if (len == 0) return 1;
      if (len > PAT_W) return PAT_W;
      return int'(len);
   endfunction

   function automatic rsp_beat_type make_beat(input logic [CHAR_W-1:0] ch, input logic valid,
                                              input logic hit);
      rsp_beat_type b;
      b.out_char   = ch;
      b.char_valid = valid;
      b.matched    = hit;
      b.last       = 1'b0;
      return b;
   endfunction

   // Advance the matcher by one request and queue the response beats it owes.
   task automatic step_matcher(input req_item_type it);
      rsp_beat_type burst[$];
      rsp_beat_type b;
      logic [CHAR_W-1:0] oldest;
      int span, i, j;
      logic hit;
      case (it.kind)
         KIND_LOAD_MASK: mask_tab[it.char_code] = it.mask_word;
         KIND_LOAD_NL:   nl_tab[it.position] = it.nl_count;
         KIND_RESTART: begin
            match_vec = '0;
            fill = 0;
         end
         default: begin
            span = window_span(cfg_len);
            if (wr_ptr >= span) wr_ptr = 0;
            ring[wr_ptr] = it.char_code;
            wr_ptr = (wr_ptr + 1) % span;
            if (fill < span) fill++;
            else fill = span;
            match_vec = ((match_vec << 1) | PAT_W'(1)) & mask_tab[it.char_code];
            hit = match_vec[span-1];
            if (hit) begin
               // Walk the window from its oldest character.
               for (i = 0; i < span; i++) begin
                  for (j = 0; j < nl_tab[i]; j++)
                     burst.push_back(make_beat(NEWLINE_CODE, 1'b1, 1'b1));
                  if (cfg_keep[i])
                     burst.push_back(make_beat(ring[(wr_ptr + i) % span], 1'b1, 1'b1));
               end
               fill = 0;
            end else if (fill == span) begin
               // Full window passes its oldest character on, newline as space.
               oldest = ring[wr_ptr];
               if (oldest == NEWLINE_CODE) oldest = SPACE_CODE;
               burst.push_back(make_beat(oldest, 1'b1, 1'b0));
            end
            if (burst.size() == 0) burst.push_back(make_beat('0, 1'b0, hit));
            foreach (burst[k]) begin
               b = burst[k];
               b.last = (k == burst.size() - 1);
               owed_beats.push_back(b);
            end
         end
      endcase
   endtask

   // Request driver: accepts a beat, then offers the next one or idles.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            step_matcher(cur_item);
            req_beats++;
            if (cur_item.kind == KIND_TEXT) text_beats++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               cur_item = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_W'({cur_item.nl_count, cur_item.position,
                                          cur_item.mask_word, cur_item.char_code});
               req_tuser  <= cur_item.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each beat against the oldest owed beat.
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            if (rsp_tuser[1]) match_beats++;
            if (owed_beats.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response beat: char %h valid %b matched %b last %b",
                        $time, rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast);
            end else begin
               want = owed_beats.pop_front();
               if (want.out_char !== rsp_tdata || want.char_valid !== rsp_tuser[0] ||
                   want.matched !== rsp_tuser[1] || want.last !== rsp_tlast) begin
                  error_count++;
                  $display({"%0t: response mismatch: expected char %h valid %b matched %b ",
                            "last %b, got char %h valid %b matched %b last %b"},
                           $time, want.out_char, want.char_valid, want.matched, want.last,
                           rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Register write; the block is idle whenever this is called.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_PATTERN_LENGTH) cfg_len = val[LEN_W-1:0];
      else cfg_keep = val;
   endtask

   // Wait until every request is taken and every owed beat has arrived.
   task automatic wait_for_idle();
      while (req_backlog.size() != 0 || req_tvalid || owed_beats.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic req_item_type rand_item(input logic [KIND_W-1:0] kind);
      req_item_type it;
      it.kind      = kind;
      it.char_code = CHAR_W'($urandom);
      it.mask_word = PAT_W'($urandom);
      it.position  = POS_W'($urandom);
      it.nl_count  = NL_W'($urandom);
      return it;
   endfunction

   task automatic push_text(input logic [CHAR_W-1:0] ch);
      req_item_type it;
      it = rand_item(KIND_TEXT);
      it.char_code = ch;
      req_backlog.push_back(it);
   endtask

   task automatic push_mask(input logic [CHAR_W-1:0] ch, input logic [PAT_W-1:0] mask);
      req_item_type it;
      it = rand_item(KIND_LOAD_MASK);
      it.char_code = ch;
      it.mask_word = mask;
      req_backlog.push_back(it);
   endtask

   task automatic push_newlines(input logic [POS_W-1:0] pos, input logic [NL_W-1:0] cnt);
      req_item_type it;
      it = rand_item(KIND_LOAD_NL);
      it.position = pos;
      it.nl_count = cnt;
      req_backlog.push_back(it);
   endtask

   // One register setting: load a pattern, then mostly text that contains it,
   // with some noise. The sender drains completely halfway through.
   task automatic run_phase(input logic [CSR_DATA_W-1:0] len_val,
                            input logic [CSR_DATA_W-1:0] keep_val,
                            input bit nl_full, input bit warm_up,
                            input int send_pct, input int recv_pct, input int n_items);
      logic [CHAR_W-1:0] alpha [4];
      logic [CHAR_W-1:0] pat [WIN_DEPTH];
      logic [PAT_W-1:0]  mask;
      int span, made, half, r, i, k;
      span = window_span(len_val[LEN_W-1:0]);
      sender_idle_pct = send_pct;
      recv_stall_pct  = recv_pct;
      write_reg(CSR_PATTERN_LENGTH, len_val);
      write_reg(CSR_KEEP_MASK, keep_val);
      @(negedge clock);
      // Fill every window slot once, with characters that cannot match.
      if (warm_up) begin
         req_backlog.push_back(rand_item(KIND_RESTART));
         for (i = 0; i < WIN_DEPTH; i++) push_text(CHAR_W'(8'h41 + i));
      end
      for (i = 0; i < span; i++)
         push_newlines(POS_W'(i), nl_full ? 2'd3 : NL_W'($urandom_range(0, 3)));
      for (k = 0; k < 3; k++) alpha[k] = CHAR_W'($urandom);
      alpha[3] = NEWLINE_CODE;
      for (i = 0; i < span; i++) pat[i] = alpha[$urandom_range(0, 3)];
      for (k = 0; k < 4; k++) begin
         mask = '0;
         for (i = 0; i < span; i++)
            if (pat[i] == alpha[k]) mask[i] = 1'b1;
         push_mask(alpha[k], mask);
      end
      req_backlog.push_back(rand_item(KIND_RESTART));
      made = 0;
      for (half = 1; half <= 2; half++) begin
         while (made < n_items * half / 2) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               for (i = 0; i < span; i++) push_text(pat[i]);
               made += span;
            end else begin
               if (r < 80) push_text(alpha[$urandom_range(0, 3)]);
               else if (r < 88) push_text(CHAR_W'($urandom));
               else if (r < 91) req_backlog.push_back(rand_item(KIND_RESTART));
               else if (r < 95) req_backlog.push_back(rand_item(KIND_LOAD_MASK));
               else req_backlog.push_back(rand_item(KIND_LOAD_NL));
               made++;
            end
         end
         wait_for_idle();
      end
   endtask

   // Stimulus and end of run.
   initial begin
      cfg_len   = 5'd1;
      cfg_keep  = '0;
      match_vec = '0;
      wr_ptr    = 0;
      fill      = 0;
      foreach (ring[i]) ring[i] = '0;
      foreach (mask_tab[i]) mask_tab[i] = '0;
      foreach (nl_tab[i]) nl_tab[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset settings, one-character window.
      push_text(8'h00);
      push_text(8'hFF);
      push_text(NEWLINE_CODE);
      push_mask(8'hFF, 16'hFFFF);
      push_mask(8'h00, 16'h0000);
      push_newlines(4'd0, 2'd0);
      // A match with nothing to emit gives a status-only beat.
      push_text(8'hFF);
      push_newlines(4'd15, 2'd3);
      push_newlines(4'd0, 2'd3);
      push_text(8'hFF);
      req_backlog.push_back(rand_item(KIND_RESTART));
      push_text(8'h41);
      wait_for_idle();

      // Full window, every beat kept, most newlines: the longest walks.
      run_phase(16'd31, 16'hFFFF, 1'b1, 1'b1, 0, 0, 22);
      run_phase(16'd0, 16'($urandom), 1'b0, 1'b0, 68, 0, 22);
      run_phase(16'($urandom_range(2, 15)), 16'($urandom), 1'b0, 1'b0, 0, 68, 22);
      run_phase(16'd16, 16'h0000, 1'b0, 1'b0, 21, 21, 22);

      $display("Covered %0d request beats (%0d text) and %0d response beats, %0d from matches,",
               req_beats, text_beats, rsp_beats, match_beats);
      $display("over five register settings with idle, stall and drain patterns on both sides.");
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
